FILE: hdl/ngh_pkg.sv
package ngh_pkg;

    localparam int MAX_AXES   = 3;
    localparam int GRID_DEPTH = 4096;
    localparam int FRAC_BITS  = 8;
    localparam int COUNT_BITS = 32;

    localparam int COORD_W   = 24;
    localparam int SIZE_W    = 13;
    localparam int AXES_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam int OP_W      = 2;
    localparam int CNT_OUT_W = 32;
    localparam int ADDR_W    = $clog2(GRID_DEPTH);
    localparam int PTR_W     = ADDR_W + 1;
    localparam int BIN_W     = SIZE_W;
    localparam int MID_W     = 2 * SIZE_W;
    localparam int FLAT_W    = MID_W + SIZE_W;
    localparam int HALF      = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXES  = 2'd0,
        CFG_SIZE0 = 2'd1,
        CFG_SIZE1 = 2'd2,
        CFG_SIZE2 = 2'd3
    } t_cfg_idx;

    // what the back end has to do with one request
    typedef enum logic [1:0] {
        BK_ADD,
        BK_READ,
        BK_CLEAR,
        BK_ZERO
    } t_bk_op;

    typedef struct packed {
        t_bk_op              kind;
        logic [ADDR_W-1:0]   addr;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_WAIT,
        ST_SWEEP
    } t_bk_state;

endpackage

FILE: hdl/ngh_front.sv
module ngh_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_take,
    input  logic [ngh_pkg::OP_W-1:0]              i_op,
    input  logic signed [ngh_pkg::COORD_W-1:0]    i_coord_a,
    input  logic signed [ngh_pkg::COORD_W-1:0]    i_coord_b,
    input  logic signed [ngh_pkg::COORD_W-1:0]    i_coord_c,
    input  logic [ngh_pkg::ADDR_W-1:0]            i_read_bin,
    input  logic [ngh_pkg::AXES_W-1:0]            i_active_axes,
    input  logic [ngh_pkg::SIZE_W-1:0]            i_size0,
    input  logic [ngh_pkg::SIZE_W-1:0]            i_size1,
    input  logic [ngh_pkg::SIZE_W-1:0]            i_size2,
    input  logic                                  i_full,
    output logic                                  o_push,
    output ngh_pkg::t_cmd                         o_cmd,
    output logic                                  o_stall
);

    // {in range, rounded bin}; halves go away from zero
    function automatic logic [ngh_pkg::BIN_W:0] ax_round(
        input logic signed [ngh_pkg::COORD_W-1:0] x,
        input logic [ngh_pkg::SIZE_W-1:0]         size
    );
        logic [ngh_pkg::COORD_W-1:0] mag;
        logic [ngh_pkg::COORD_W:0]   sum;
        logic [ngh_pkg::COORD_W:0]   rnd;
        logic                        ok;
        mag = x[ngh_pkg::COORD_W-1] ? ngh_pkg::COORD_W'(-x) : ngh_pkg::COORD_W'(x);
        sum = {1'b0, mag} + (ngh_pkg::COORD_W+1)'(ngh_pkg::HALF);
        rnd = sum >> ngh_pkg::FRAC_BITS;
        // negative input that rounds to zero still lands on bin 0
        ok  = (!x[ngh_pkg::COORD_W-1] || (rnd == '0))
              && (rnd < (ngh_pkg::COORD_W+1)'(size));
        return {ok, rnd[ngh_pkg::BIN_W-1:0]};
    endfunction

    logic [ngh_pkg::AXES_W-1:0]  w_axes;
    logic [ngh_pkg::BIN_W:0]     w_ax0, w_ax1, w_ax2;
    logic                        w_adv;

    logic                        r_v1, r_v2, r_v3;
    ngh_pkg::t_op                r_op1, r_op2, r_op3;
    logic                        r_ok1, r_ok2, r_ok3;
    logic [ngh_pkg::BIN_W-1:0]   r_b0, r_b1, r_b2, r_b2b;
    logic [ngh_pkg::SIZE_W-1:0]  r_s1, r_s2, r_s2b;
    logic [ngh_pkg::ADDR_W-1:0]  r_rb1, r_rb2, r_rb3;
    logic [ngh_pkg::MID_W-1:0]   r_mid;
    logic [ngh_pkg::FLAT_W-1:0]  r_flat;

    logic                        n_ok1;
    logic [ngh_pkg::BIN_W-1:0]   n_b1, n_b2;
    logic [ngh_pkg::SIZE_W-1:0]  n_s1, n_s2;
    logic [ngh_pkg::MID_W-1:0]   n_mid;
    logic [ngh_pkg::FLAT_W-1:0]  n_flat;

    always_comb begin
        w_axes = (i_active_axes == '0) ? ngh_pkg::AXES_W'(1) : i_active_axes;
        if ({1'b0, w_axes} > (ngh_pkg::AXES_W+1)'(ngh_pkg::MAX_AXES)) begin
            w_axes = ngh_pkg::AXES_W'(ngh_pkg::MAX_AXES);
        end
    end

    assign w_ax0 = ax_round(i_coord_a, i_size0);
    assign w_ax1 = ax_round(i_coord_b, i_size1);
    assign w_ax2 = ax_round(i_coord_c, i_size2);

    // unused axes act as size 1, bin 0 so the flattening needs no special case
    always_comb begin
        n_ok1 = w_ax0[ngh_pkg::BIN_W];
        n_b1  = '0;
        n_b2  = '0;
        n_s1  = ngh_pkg::SIZE_W'(1);
        n_s2  = ngh_pkg::SIZE_W'(1);
        if (w_axes >= ngh_pkg::AXES_W'(2)) begin
            n_ok1 = n_ok1 && w_ax1[ngh_pkg::BIN_W];
            n_b1  = w_ax1[ngh_pkg::BIN_W-1:0];
            n_s1  = i_size1;
        end
        if (w_axes >= ngh_pkg::AXES_W'(3)) begin
            n_ok1 = n_ok1 && w_ax2[ngh_pkg::BIN_W];
            n_b2  = w_ax2[ngh_pkg::BIN_W-1:0];
            n_s2  = i_size2;
        end
    end

    assign n_mid  = r_b0 * r_s1 + ngh_pkg::MID_W'(r_b1);
    assign n_flat = r_mid * r_s2b + ngh_pkg::FLAT_W'(r_b2b);

    assign o_stall = r_v3 && i_full;
    assign o_push  = r_v3 && !i_full;
    assign w_adv   = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1  <= ngh_pkg::t_op'(i_op);
            r_ok1  <= n_ok1;
            r_b0   <= w_ax0[ngh_pkg::BIN_W-1:0];
            r_b1   <= n_b1;
            r_b2   <= n_b2;
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_rb1  <= i_read_bin;

            r_op2  <= r_op1;
            r_ok2  <= r_ok1;
            r_mid  <= n_mid;
            r_b2b  <= r_b2;
            r_s2b  <= r_s2;
            r_rb2  <= r_rb1;

            r_op3  <= r_op2;
            r_ok3  <= r_ok2;
            r_flat <= n_flat;
            r_rb3  <= r_rb2;
        end
    end

    always_comb begin
        o_cmd.kind = ngh_pkg::BK_ZERO;
        o_cmd.addr = '0;
        unique case (r_op3)
            ngh_pkg::OP_ADD: begin
                if (r_ok3 && (r_flat < ngh_pkg::FLAT_W'(ngh_pkg::GRID_DEPTH))) begin
                    o_cmd.kind = ngh_pkg::BK_ADD;
                    o_cmd.addr = r_flat[ngh_pkg::ADDR_W-1:0];
                end
            end
            ngh_pkg::OP_READ: begin
                o_cmd.kind = ngh_pkg::BK_READ;
                o_cmd.addr = r_rb3;
            end
            ngh_pkg::OP_CLEAR: begin
                o_cmd.kind = ngh_pkg::BK_CLEAR;
            end
            ngh_pkg::OP_NONE: begin
                o_cmd.kind = ngh_pkg::BK_ZERO;
            end
            default: begin
                o_cmd.kind = ngh_pkg::BK_ZERO;
            end
        endcase
    end

endmodule

FILE: hdl/ngh_fifo.sv
module ngh_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ngh_pkg::t_cmd  i_data,
    input  logic           i_pop,
    output ngh_pkg::t_cmd  o_data,
    output logic           o_full,
    output logic           o_empty
);

    ngh_pkg::t_cmd                r_mem [ngh_pkg::QUEUE_DEPTH];
    logic [ngh_pkg::Q_PTR_W-1:0]  r_wp, r_rp;
    logic [ngh_pkg::Q_PTR_W:0]    r_cnt;
    logic                         w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (ngh_pkg::Q_PTR_W+1)'(ngh_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hdl/ngh_back.sv
module ngh_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  ngh_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              o_init_busy,
    output logic                              o_valid,
    output logic [ngh_pkg::CNT_OUT_W-1:0]     o_count,
    output logic                              o_inside_res,
    output logic [ngh_pkg::ADDR_W-1:0]        o_flat_bin
);

    logic [ngh_pkg::COUNT_BITS-1:0] r_mem [ngh_pkg::GRID_DEPTH];
    logic [ngh_pkg::COUNT_BITS-1:0] r_rdata;

    ngh_pkg::t_bk_state             r_state, n_state;
    logic [ngh_pkg::PTR_W-1:0]      r_ptr, n_ptr;
    ngh_pkg::t_cmd                  r_cmd;

    logic                           r_valid, n_valid;
    logic [ngh_pkg::CNT_OUT_W-1:0]  r_count, n_count;
    logic                           r_inside, n_inside;
    logic [ngh_pkg::ADDR_W-1:0]     r_flat, n_flat;

    logic                           w_we, w_re, w_last;
    logic [ngh_pkg::ADDR_W-1:0]     w_waddr, w_raddr;
    logic [ngh_pkg::COUNT_BITS-1:0] w_wdata, w_inc;

    assign w_last = (r_ptr == ngh_pkg::PTR_W'(ngh_pkg::GRID_DEPTH - 1));
    // counters stick at full scale
    assign w_inc  = (r_rdata == ngh_pkg::COUNT_MAX)
                    ? r_rdata : r_rdata + ngh_pkg::COUNT_BITS'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ngh_pkg::ST_INIT, ngh_pkg::ST_SWEEP: begin
                if (w_last) begin
                    n_state = ngh_pkg::ST_IDLE;
                end
            end
            ngh_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        ngh_pkg::BK_ADD, ngh_pkg::BK_READ: n_state = ngh_pkg::ST_WAIT;
                        ngh_pkg::BK_CLEAR:                 n_state = ngh_pkg::ST_SWEEP;
                        default:                           n_state = ngh_pkg::ST_IDLE;
                    endcase
                end
            end
            ngh_pkg::ST_WAIT: begin
                n_state = ngh_pkg::ST_IDLE;
            end
            default: begin
                n_state = ngh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_ptr[ngh_pkg::ADDR_W-1:0];
        w_wdata  = '0;
        w_re     = 1'b0;
        w_raddr  = i_cmd.addr;
        n_ptr    = r_ptr;
        n_valid  = 1'b0;
        n_count  = '0;
        n_inside = 1'b0;
        n_flat   = '0;
        unique case (r_state)
            ngh_pkg::ST_INIT, ngh_pkg::ST_SWEEP: begin
                w_we  = 1'b1;
                n_ptr = w_last ? '0 : r_ptr + 1'b1;
            end
            ngh_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        ngh_pkg::BK_ADD, ngh_pkg::BK_READ: begin
                            w_re = 1'b1;
                        end
                        default: begin
                            // clear and dropped requests answer with zeros at once
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ngh_pkg::ST_WAIT: begin
                n_valid = 1'b1;
                n_flat  = r_cmd.addr;
                if (r_cmd.kind == ngh_pkg::BK_ADD) begin
                    w_we     = 1'b1;
                    w_waddr  = r_cmd.addr;
                    w_wdata  = w_inc;
                    n_count  = ngh_pkg::CNT_OUT_W'(w_inc);
                    n_inside = 1'b1;
                end else begin
                    n_count  = ngh_pkg::CNT_OUT_W'(r_rdata);
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ngh_pkg::ST_INIT;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_count  <= n_count;
        r_inside <= n_inside;
        r_flat   <= n_flat;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_init_busy  = (r_state == ngh_pkg::ST_INIT);
    assign o_valid      = r_valid;
    assign o_count      = r_count;
    assign o_inside_res = r_inside;
    assign o_flat_bin   = r_flat;

endmodule

FILE: hdl/nd_grid_event_histogram.sv
// Event histogram over a grid of one to three axes, 4096 saturating counters.
// Request channel: i_op with i_coord_a/b/c (signed, 8 fraction bits) and
// i_read_bin, taken on a clock edge with i_start high and o_busy low.
// op 0 adds an event, 1 reads a counter, 2 clears all counters.
// Result channel: o_valid strobes one cycle with o_count, o_inside_res and
// o_flat_bin; exactly one result per request, in request order. The receiver
// cannot stall, so results never wait.
// Add and read pass the front end, the queue, a memory read and ST_WAIT; clear
// and dropped events skip the read and ST_WAIT. The front end (round, range
// check, two multiply stages for row-major flattening) takes a request every
// cycle when not stalled; a 4-entry queue separates it from the single-port
// counter memory, which ends each add or read before it pops the next. A
// clear answers at once, then sweeps all 4096 counters; later requests queue
// up. o_busy rises when the queue is full and the front end backs up.
// Reset: synchronous, active low. Configuration returns to 2 axes of 64 x 64,
// and a clearing pass zeroes all 4096 counters, with o_busy high.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) land at once and
// are allowed at any time outside of outstanding requests.
module nd_grid_event_histogram (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [ngh_pkg::OP_W-1:0]              i_op,
    input  logic signed [ngh_pkg::COORD_W-1:0]    i_coord_a,
    input  logic signed [ngh_pkg::COORD_W-1:0]    i_coord_b,
    input  logic signed [ngh_pkg::COORD_W-1:0]    i_coord_c,
    input  logic [ngh_pkg::ADDR_W-1:0]            i_read_bin,
    input  logic                                  i_cfg_we,
    input  logic [ngh_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ngh_pkg::CFG_W-1:0]             i_cfg_data,
    output logic                                  o_valid,
    output logic [ngh_pkg::CNT_OUT_W-1:0]         o_count,
    output logic                                  o_inside_res,
    output logic [ngh_pkg::ADDR_W-1:0]            o_flat_bin
);

    logic [ngh_pkg::AXES_W-1:0] r_active_axes;
    logic [ngh_pkg::SIZE_W-1:0] r_size0, r_size1, r_size2;

    logic           w_take, w_stall, w_init_busy;
    logic           w_push, w_pop, w_full, w_empty;
    ngh_pkg::t_cmd  w_fe_cmd, w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_axes <= ngh_pkg::AXES_W'(2);
            r_size0       <= ngh_pkg::SIZE_W'(64);
            r_size1       <= ngh_pkg::SIZE_W'(64);
            r_size2       <= ngh_pkg::SIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (ngh_pkg::t_cfg_idx'(i_cfg_index))
                ngh_pkg::CFG_AXES:  r_active_axes <= i_cfg_data[ngh_pkg::AXES_W-1:0];
                ngh_pkg::CFG_SIZE0: r_size0       <= i_cfg_data[ngh_pkg::SIZE_W-1:0];
                ngh_pkg::CFG_SIZE1: r_size1       <= i_cfg_data[ngh_pkg::SIZE_W-1:0];
                ngh_pkg::CFG_SIZE2: r_size2       <= i_cfg_data[ngh_pkg::SIZE_W-1:0];
                default:            r_size2       <= r_size2;
            endcase
        end
    end

    assign o_busy = w_init_busy || w_stall;
    assign w_take = i_start && !o_busy;

    ngh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_op          (i_op),
        .i_coord_a     (i_coord_a),
        .i_coord_b     (i_coord_b),
        .i_coord_c     (i_coord_c),
        .i_read_bin    (i_read_bin),
        .i_active_axes (r_active_axes),
        .i_size0       (r_size0),
        .i_size1       (r_size1),
        .i_size2       (r_size2),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_fe_cmd),
        .o_stall       (w_stall)
    );

    ngh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fe_cmd),
        .i_pop   (w_pop),
        .o_data  (w_q_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ngh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .o_init_busy  (w_init_busy),
        .o_valid      (o_valid),
        .o_count      (o_count),
        .o_inside_res (o_inside_res),
        .o_flat_bin   (o_flat_bin)
    );

`ifndef SYNTHESIS
    // no result may come out while the reset clearing pass is still zeroing the memory
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !o_valid)
        else $error("result during reset clearing pass");

    // a counted event is at least one, saturation never wraps to zero
    a_add_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_res) |-> (o_count != '0))
        else $error("counted event reports zero count");

    // the queue is drained only by the back end while it is not zeroing memory
    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !w_pop)
        else $error("request taken from queue during clearing pass");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HIT_KEEP    = 32;

    typedef struct packed {
        ngh_pkg::t_op                        op;
        logic signed [ngh_pkg::COORD_W-1:0]  coord_a;
        logic signed [ngh_pkg::COORD_W-1:0]  coord_b;
        logic signed [ngh_pkg::COORD_W-1:0]  coord_c;
        logic [ngh_pkg::ADDR_W-1:0]          read_bin;
    } t_hist_req;

    typedef struct packed {
        logic [ngh_pkg::CNT_OUT_W-1:0]  count;
        logic                           inside_res;
        logic [ngh_pkg::ADDR_W-1:0]     flat_bin;
    } t_hist_res;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_start = 1'b0;
    logic                                o_busy;
    logic [ngh_pkg::OP_W-1:0]            i_op = ngh_pkg::OP_ADD;
    logic signed [ngh_pkg::COORD_W-1:0]  i_coord_a = '0;
    logic signed [ngh_pkg::COORD_W-1:0]  i_coord_b = '0;
    logic signed [ngh_pkg::COORD_W-1:0]  i_coord_c = '0;
    logic [ngh_pkg::ADDR_W-1:0]          i_read_bin = '0;
    logic                                i_cfg_we = 1'b0;
    logic [ngh_pkg::CFG_IDX_W-1:0]       i_cfg_index = ngh_pkg::CFG_AXES;
    logic [ngh_pkg::CFG_W-1:0]           i_cfg_data = '0;
    logic                                o_valid;
    logic [ngh_pkg::CNT_OUT_W-1:0]       o_count;
    logic                                o_inside_res;
    logic [ngh_pkg::ADDR_W-1:0]          o_flat_bin;

    nd_grid_event_histogram u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_op         (i_op),
        .i_coord_a    (i_coord_a),
        .i_coord_b    (i_coord_b),
        .i_coord_c    (i_coord_c),
        .i_read_bin   (i_read_bin),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_count      (o_count),
        .o_inside_res (o_inside_res),
        .o_flat_bin   (o_flat_bin)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the histogram
    logic [ngh_pkg::COUNT_BITS-1:0]  tally_mem [ngh_pkg::GRID_DEPTH];
    logic [ngh_pkg::AXES_W-1:0]      axes_cfg = 2'd2;
    logic [ngh_pkg::SIZE_W-1:0]      axis_size [3];

    t_hist_req  event_reqs_q [$];
    t_hist_res  bin_answers_q [$];
    int         hit_addrs [$];

    int unsigned cycle_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned issued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned landed_cnt = 0;
    int unsigned dropped_cnt = 0;
    int unsigned read_cnt = 0;
    int unsigned clear_cnt = 0;
    int unsigned setting_cnt = 1;

    t_hist_req  drv_req;
    t_hist_req  next_req;
    t_hist_res  want;
    int         burst_left = 0;
    int         gap_left = 0;

    initial begin
        for (int i = 0; i < ngh_pkg::GRID_DEPTH; i++) tally_mem[i] = '0;
        axis_size[0] = 13'd64;
        axis_size[1] = 13'd64;
        axis_size[2] = 13'd1;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic logic signed [ngh_pkg::COORD_W-1:0] coord_of(t_hist_req r, int axis);
        case (axis)
            0:       return r.coord_a;
            1:       return r.coord_b;
            default: return r.coord_c;
        endcase
    endfunction

    // flat counter address an add lands on, -1 when the event is dropped
    function automatic longint land_index(t_hist_req r);
        int     axes;
        longint x;
        longint mag;
        longint rb;
        longint flat;
        axes = (axes_cfg == 0) ? 1 : int'(axes_cfg);
        if (axes > ngh_pkg::MAX_AXES) axes = ngh_pkg::MAX_AXES;
        flat = 0;
        for (int a = 0; a < axes; a++) begin
            x   = longint'(coord_of(r, a));
            mag = (x < 0) ? -x : x;
            rb  = (mag + ngh_pkg::HALF) >>> ngh_pkg::FRAC_BITS;
            if (x < 0) rb = -rb;
            if (rb < 0 || rb >= longint'(axis_size[a])) return -1;
            flat = flat * longint'(axis_size[a]) + rb;
        end
        if (flat >= ngh_pkg::GRID_DEPTH) return -1;
        return flat;
    endfunction

    function automatic t_hist_res tally_request(t_hist_req r);
        t_hist_res res;
        longint    idx;
        res = '0;
        case (r.op)
            ngh_pkg::OP_ADD: begin
                idx = land_index(r);
                if (idx >= 0) begin
                    if (tally_mem[idx] != ngh_pkg::COUNT_MAX)
                        tally_mem[idx] = tally_mem[idx] + 1'b1;
                    res.count      = tally_mem[idx][ngh_pkg::CNT_OUT_W-1:0];
                    res.inside_res = 1'b1;
                    res.flat_bin   = idx[ngh_pkg::ADDR_W-1:0];
                    landed_cnt++;
                end else begin
                    dropped_cnt++;
                end
            end
            ngh_pkg::OP_READ: begin
                res.count    = tally_mem[r.read_bin][ngh_pkg::CNT_OUT_W-1:0];
                res.flat_bin = r.read_bin;
                read_cnt++;
            end
            ngh_pkg::OP_CLEAR: begin
                for (int i = 0; i < ngh_pkg::GRID_DEPTH; i++) tally_mem[i] = '0;
                clear_cnt++;
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver: bursts of requests with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                bin_answers_q.push_back(tally_request(drv_req));
                accepted_cnt++;
            end
            if (i_start && o_busy) begin
                // hold the request until taken
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_start <= 1'b0;
            end else if (event_reqs_q.size() > 0) begin
                next_req = event_reqs_q.pop_front();
                drv_req  = next_req;
                i_start    <= 1'b1;
                i_op       <= next_req.op;
                i_coord_a  <= next_req.coord_a;
                i_coord_b  <= next_req.coord_b;
                i_coord_c  <= next_req.coord_c;
                i_read_bin <= next_req.read_bin;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, so check every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (bin_answers_q.size() == 0) begin
                report_mismatch($sformatf("result with no request outstanding (count %0d bin %0d)",
                                          o_count, o_flat_bin));
            end else begin
                want = bin_answers_q.pop_front();
                if (o_count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d", o_count, want.count));
                if (o_inside_res !== want.inside_res)
                    report_mismatch($sformatf("inside_res %b, expected %b",
                                              o_inside_res, want.inside_res));
                if (o_flat_bin !== want.flat_bin)
                    report_mismatch($sformatf("flat_bin %0d, expected %0d",
                                              o_flat_bin, want.flat_bin));
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, bin_answers_q.size());
        $display("simulation failed");
        $finish;
    end

    function automatic t_hist_req mk(ngh_pkg::t_op op, int a, int b, int c, int rb);
        t_hist_req r;
        r.op       = op;
        r.coord_a  = a[ngh_pkg::COORD_W-1:0];
        r.coord_b  = b[ngh_pkg::COORD_W-1:0];
        r.coord_c  = c[ngh_pkg::COORD_W-1:0];
        r.read_bin = rb[ngh_pkg::ADDR_W-1:0];
        return r;
    endfunction

    task automatic send(t_hist_req r);
        event_reqs_q.push_back(r);
        issued_cnt++;
    endtask

    task automatic wait_drained();
        while (accepted_cnt != issued_cnt || bin_answers_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(ngh_pkg::t_cfg_idx idx, logic [ngh_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            ngh_pkg::CFG_AXES:  axes_cfg = val[ngh_pkg::AXES_W-1:0];
            ngh_pkg::CFG_SIZE0: axis_size[0] = val;
            ngh_pkg::CFG_SIZE1: axis_size[1] = val;
            default:            axis_size[2] = val;
        endcase
    endtask

    // coordinate near the grid on one axis, halves and edges included
    function automatic int near_coord(int size);
        int hi;
        int pos;
        int frac;
        if ($urandom_range(0, 6) == 0) return int'($urandom);
        hi = (size > 0) ? size - 1 : 0;
        case ($urandom_range(0, 9))
            0:       pos = -1;
            1:       pos = size;
            2, 3, 4: pos = $urandom_range(0, (hi < 3) ? hi : 3);
            default: pos = $urandom_range(0, hi);
        endcase
        case ($urandom_range(0, 5))
            0:       frac = -ngh_pkg::HALF;
            1:       frac = ngh_pkg::HALF;
            2:       frac = ngh_pkg::HALF - 1;
            default: frac = int'($urandom_range(0, 2 * ngh_pkg::HALF - 1)) - ngh_pkg::HALF;
        endcase
        return (pos <<< ngh_pkg::FRAC_BITS) + frac;
    endfunction

    function automatic t_hist_req make_request();
        t_hist_req r;
        int        pick;
        longint    idx;
        r = mk(ngh_pkg::OP_ADD, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        pick = $urandom_range(0, 999);
        if (pick < 7) begin
            r.op = ngh_pkg::OP_CLEAR;
        end else if (pick < 27) begin
            r.op = ngh_pkg::OP_NONE;
        end else if (pick < 230) begin
            r.op = ngh_pkg::OP_READ;
            if (hit_addrs.size() > 0 && $urandom_range(0, 9) < 6)
                r.read_bin = ngh_pkg::ADDR_W'(hit_addrs[$urandom_range(0, hit_addrs.size() - 1)]);
        end else begin
            r.coord_a = ngh_pkg::COORD_W'(near_coord(int'(axis_size[0])));
            r.coord_b = ngh_pkg::COORD_W'(near_coord(int'(axis_size[1])));
            r.coord_c = ngh_pkg::COORD_W'(near_coord(int'(axis_size[2])));
            idx = land_index(r);
            if (idx >= 0) begin
                hit_addrs.push_back(int'(idx));
                if (hit_addrs.size() > HIT_KEEP) void'(hit_addrs.pop_front());
            end
        end
        return r;
    endfunction

    task automatic run_setting(int axes, int s0, int s1, int s2, int n);
        cfg_write(ngh_pkg::CFG_AXES, ngh_pkg::CFG_W'(axes));
        cfg_write(ngh_pkg::CFG_SIZE0, ngh_pkg::CFG_W'(s0));
        cfg_write(ngh_pkg::CFG_SIZE1, ngh_pkg::CFG_W'(s1));
        cfg_write(ngh_pkg::CFG_SIZE2, ngh_pkg::CFG_W'(s2));
        i_cfg_we <= 1'b0;
        setting_cnt++;
        hit_addrs.delete();
        for (int i = 0; i < n; i++) send(make_request());
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests on the reset grid, 2 axes of 64 x 64
        send(mk(ngh_pkg::OP_ADD, 0, 0, 0, 0));
        send(mk(ngh_pkg::OP_ADD, ngh_pkg::HALF - 1, ngh_pkg::HALF, 0, 0));   // half rounds up
        send(mk(ngh_pkg::OP_ADD, -ngh_pkg::HALF, 0, 0, 0));                 // half rounds to -1
        send(mk(ngh_pkg::OP_ADD, -(ngh_pkg::HALF - 1), -(ngh_pkg::HALF - 1), 0, 0));
        send(mk(ngh_pkg::OP_ADD, (63 << ngh_pkg::FRAC_BITS) + ngh_pkg::HALF - 1,
                63 << ngh_pkg::FRAC_BITS, 0, 0));
        send(mk(ngh_pkg::OP_ADD, (63 << ngh_pkg::FRAC_BITS) + ngh_pkg::HALF - 1,
                63 << ngh_pkg::FRAC_BITS, 0, 0));
        send(mk(ngh_pkg::OP_ADD, (63 << ngh_pkg::FRAC_BITS) + ngh_pkg::HALF,
                0, 0, 0));                                                  // one past the edge
        send(mk(ngh_pkg::OP_ADD, 'h7FFFFF, 0, 0, 0));
        send(mk(ngh_pkg::OP_ADD, 0, 'h800000, 0, 0));
        send(mk(ngh_pkg::OP_ADD, 1 << ngh_pkg::FRAC_BITS, 2 << ngh_pkg::FRAC_BITS,
                'h7FFFFF, 'hFFF));                                          // c unused
        send(mk(ngh_pkg::OP_READ, 'h7FFFFF, 'h800000, -1, 0));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 1));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 4095));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 66));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 5));
        send(mk(ngh_pkg::OP_NONE, 'h7FFFFF, 'h800000, 'h5A5A5A, 'hFFF));
        send(mk(ngh_pkg::OP_CLEAR, 'h123456, 'h654321, 'h7FFFFF, 'hABC));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 0));
        send(mk(ngh_pkg::OP_ADD, 0, 0, 0, 0));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 0));
        send(mk(ngh_pkg::OP_READ, 0, 0, 0, 4095));
        wait_drained();

        run_setting(1, 4096, $urandom_range(1, 8191), $urandom_range(1, 8191), 260);
        run_setting(3, 16, 16, 16, 260);
        run_setting(3, 4, 5, 3, 260);
        run_setting(0, 7, $urandom_range(0, 8191), $urandom_range(0, 8191), 200);
        run_setting(3, 4096, 4096, 4096, 220);
        run_setting(2, 1, 1, $urandom_range(0, 8191), 120);
        run_setting(2, 64, 0, 1, 80);                            // zero sized axis
        run_setting(2, 8191, 1, $urandom_range(0, 8191), 200);
        run_setting(2, 64, 64, 1, 300);

        repeat (20) @(posedge i_clk);
        $display("%0d requests over %0d grid settings: %0d events counted, %0d dropped",
                 accepted_cnt, setting_cnt, landed_cnt, dropped_cnt);
        $display("%0d counter reads, %0d clears, %0d mismatches",
                 read_cnt, clear_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
